/* sv/ebc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_pkg
// Shared constants and types of the 8-bit CPU core.
// ----------------------------------------------------------------------------
package ebc_pkg;
    localparam int ADDR_BITS = 16;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    localparam logic [15:0] PC_RESET = 16'h0101;
    localparam logic [15:0] SP_RESET = 16'hFFFE;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [7:0] OP_STOP  = 8'h10;
    localparam logic [7:0] OP_HALT  = 8'h76;
    localparam logic [7:0] OP_LDBLK = 8'h40;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [7:0] value;
        logic [3:0] flags;
    } alu_res_t;
endpackage

/* sv/ebc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ebc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* sv/ebc_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebc_alu
// 8-bit increment, decrement, rotate, DAA, CPL, SCF and CCF with flags.
// ----------------------------------------------------------------------------
module ebc_alu (
    input  logic [7:0]        op,
    input  logic [7:0]        operand,
    input  logic [7:0]        acc,
    input  logic [3:0]        flags,
    output ebc_pkg::alu_res_t res
);
    import ebc_pkg::*;

    logic [2:0] y;
    logic [7:0] adj;
    logic [7:0] r;
    logic       c;
    logic       h;
    logic       cn;

    assign y = op[5:3];
    assign c = flags[FLAG_C];
    assign h = flags[FLAG_H];

    always_comb begin
        res = '{value: operand, flags: flags};
        adj = 8'h00;
        r   = 8'h00;
        cn  = c;
        case (op[2:0])
            3'd4: begin
                r = operand + 8'd1;
                res.value = r;
                res.flags = {r == 8'd0, 1'b0, operand[3:0] == 4'hF, c};
            end
            3'd5: begin
                r = operand - 8'd1;
                res.value = r;
                res.flags = {r == 8'd0, 1'b1, operand[3:0] == 4'h0, c};
            end
            3'd7: begin
                case (y)
                    3'd0: res = '{value: {acc[6:0], acc[7]}, flags: {3'b000, acc[7]}};
                    3'd1: res = '{value: {acc[0], acc[7:1]}, flags: {3'b000, acc[0]}};
                    3'd2: res = '{value: {acc[6:0], c}, flags: {3'b000, acc[7]}};
                    3'd3: res = '{value: {c, acc[7:1]}, flags: {3'b000, acc[0]}};
                    3'd4: begin
                        if (flags[FLAG_N]) begin
                            adj = (c ? 8'h60 : 8'h00) + (h ? 8'h06 : 8'h00);
                            r   = acc - adj;
                        end else begin
                            if (h || acc[3:0] > 4'h9) begin
                                adj = adj + 8'h06;
                            end
                            if (c || acc > 8'h99) begin
                                adj = adj + 8'h60;
                                cn  = 1'b1;
                            end
                            r = acc + adj;
                        end
                        res = '{value: r, flags: {r == 8'd0, flags[FLAG_N], 1'b0, cn}};
                    end
                    3'd5: res = '{value: ~acc, flags: {flags[FLAG_Z], 2'b11, c}};
                    3'd6: res = '{value: acc, flags: {flags[FLAG_Z], 3'b001}};
                    default: res = '{value: acc, flags: {flags[FLAG_Z], 2'b00, ~c}};
                endcase
            end
            default: res = '{value: operand, flags: flags};
        endcase
    end
endmodule

/* sv/eight_bit_cpu_load_inc_core_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_cpu_load_inc_core_unit
// Executes opcodes 0x00-0x7F of an 8-bit CPU out of a single-port byte memory.
// ----------------------------------------------------------------------------
// Sequence: memory write items go from acceptance straight to S_DONE, reads
// pass through S_RDATA, executes through S_OP and S_DEC and then, as the
// opcode needs, S_IMM_LO, S_IMM_HI, S_WR2 or S_MEMRD (the single memory port
// fetches the opcode, up to two immediates and the operand in turn).
// The next item is taken while a result waits in the output register.
// Reset: a clearing pass writes zero to all 2^ADDR_BITS bytes, one per cycle,
// before the first item is accepted.
module eight_bit_cpu_load_inc_core_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pc,
    output logic [15:0] m_sp,
    output logic [7:0]  m_acc,
    output logic [3:0]  m_flags,
    output logic [7:0]  m_reg_b,
    output logic [7:0]  m_reg_c,
    output logic [7:0]  m_reg_d,
    output logic [7:0]  m_reg_e,
    output logic [7:0]  m_reg_h,
    output logic [7:0]  m_reg_l,
    output logic [7:0]  m_read_data,
    output logic        m_status
);
    import ebc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RDATA, S_OP, S_DEC, S_IMM_LO, S_IMM_HI, S_WR2, S_MEMRD, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [7:0]  e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [3:0]  f_reg, f_next;
    logic [7:0]  op_reg, op_next, lo_reg, lo_next, hi_reg, hi_next, rd_reg, rd_next;
    logic        st_reg, st_next;

    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_pc_reg, m_sp_reg;
    logic [7:0]  m_acc_reg, m_b_reg, m_c_reg, m_d_reg, m_e_reg, m_h_reg, m_l_reg, m_rd_reg;
    logic [3:0]  m_flags_reg;
    logic        m_status_reg;

    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_wdata, mem_rdata;

    logic [2:0]  y, z;
    logic [1:0]  p;
    logic        q;
    logic [15:0] hl;
    logic [7:0]  alu_v;
    alu_res_t    alu_res;
    logic        load_out;

    assign y  = op_reg[5:3];
    assign z  = op_reg[2:0];
    assign p  = op_reg[5:4];
    assign q  = op_reg[3];
    assign hl = {h_reg, l_reg};

    function automatic logic [7:0] r8_get(input logic [2:0] i, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] e, input logic [7:0] h,
                                          input logic [7:0] l, input logic [7:0] a);
        logic [7:0] v;
        case (i)
            3'd0: v = b;
            3'd1: v = c;
            3'd2: v = d;
            3'd3: v = e;
            3'd4: v = h;
            3'd5: v = l;
            3'd7: v = a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pair_get(input logic [1:0] i, input logic [15:0] bc,
                                             input logic [15:0] de, input logic [15:0] hlv,
                                             input logic [15:0] sp);
        logic [15:0] v;
        case (i)
            2'd0: v = bc;
            2'd1: v = de;
            2'd2: v = hlv;
            default: v = sp;
        endcase
        return v;
    endfunction

    assign alu_v = (state_reg == S_MEMRD) ? mem_rdata
                 : r8_get(y, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg);

    ebc_alu u_alu (
        .op      (op_reg),
        .operand (alu_v),
        .acc     (a_reg),
        .flags   (f_reg),
        .res     (alu_res)
    );

    ebc_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        logic        r8_we;
        logic [2:0]  r8_idx;
        logic [7:0]  r8_val;
        logic        pr_we;
        logic [1:0]  pr_idx;
        logic [15:0] pr_val;
        logic [15:0] t16;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic        take;

        state_next = state_reg;
        clr_next   = clr_reg;
        pc_next = pc_reg; sp_next = sp_reg; a_next = a_reg; f_next = f_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        h_next = h_reg; l_next = l_reg;
        op_next = op_reg; lo_next = lo_reg; hi_next = hi_reg;
        rd_next = rd_reg; st_next = st_reg;
        mem_we = 1'b0; mem_addr = pc_reg[ADDR_BITS-1:0]; mem_wdata = 8'h00;
        r8_we = 1'b0; r8_idx = y; r8_val = 8'h00;
        pr_we = 1'b0; pr_idx = p; pr_val = 16'h0000;
        t16 = 16'h0000; sum17 = 17'h0; sum13 = 13'h0; take = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    rd_next = 8'h00;
                    st_next = 1'b0;
                    case (s_action)
                        ACT_EXEC: begin
                            pc_next    = pc_reg + 16'd1;
                            state_next = S_OP;
                        end
                        ACT_WRITE: begin
                            mem_we     = 1'b1;
                            mem_addr   = s_address[ADDR_BITS-1:0];
                            mem_wdata  = s_data;
                            state_next = S_DONE;
                        end
                        ACT_READ: begin
                            mem_addr   = s_address[ADDR_BITS-1:0];
                            state_next = S_RDATA;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RDATA: begin
                rd_next    = mem_rdata;
                state_next = S_DONE;
            end
            S_OP: begin
                op_next    = mem_rdata;
                state_next = S_DEC;
            end
            S_DEC: begin
                state_next = S_DONE;
                if (op_reg[7] || op_reg == OP_HALT || op_reg == OP_STOP) begin
                    st_next = 1'b1;
                end else if (op_reg >= OP_LDBLK) begin
                    if (z == 3'd6) begin
                        mem_addr   = hl[ADDR_BITS-1:0];
                        state_next = S_MEMRD;
                    end else if (y == 3'd6) begin
                        mem_we    = 1'b1;
                        mem_addr  = hl[ADDR_BITS-1:0];
                        mem_wdata = r8_get(z, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg);
                    end else begin
                        r8_we  = 1'b1;
                        r8_val = r8_get(z, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg);
                    end
                end else begin
                    case (z)
                        3'd0: begin
                            if (y != 3'd0) begin
                                pc_next    = pc_reg + 16'd1;
                                state_next = S_IMM_LO;
                            end
                        end
                        3'd1: begin
                            if (!q) begin
                                pc_next    = pc_reg + 16'd1;
                                state_next = S_IMM_LO;
                            end else begin
                                t16   = pair_get(p, {b_reg, c_reg}, {d_reg, e_reg}, hl, sp_reg);
                                sum17 = {1'b0, hl} + {1'b0, t16};
                                sum13 = {1'b0, hl[11:0]} + {1'b0, t16[11:0]};
                                f_next = {f_reg[FLAG_Z], 1'b0, sum13[12], sum17[16]};
                                pr_we  = 1'b1;
                                pr_idx = 2'd2;
                                pr_val = sum17[15:0];
                            end
                        end
                        3'd2: begin
                            t16 = pair_get(p[1] ? 2'd2 : p, {b_reg, c_reg}, {d_reg, e_reg},
                                           hl, sp_reg);
                            pr_idx = 2'd2;
                            if (p == 2'd2) begin
                                pr_we  = 1'b1;
                                pr_val = t16 + 16'd1;
                            end else if (p == 2'd3) begin
                                pr_we  = 1'b1;
                                pr_val = t16 - 16'd1;
                            end
                            mem_addr = t16[ADDR_BITS-1:0];
                            if (!q) begin
                                mem_we    = 1'b1;
                                mem_wdata = a_reg;
                            end else begin
                                state_next = S_MEMRD;
                            end
                        end
                        3'd3: begin
                            t16    = pair_get(p, {b_reg, c_reg}, {d_reg, e_reg}, hl, sp_reg);
                            pr_we  = 1'b1;
                            pr_val = q ? t16 - 16'd1 : t16 + 16'd1;
                        end
                        3'd4, 3'd5: begin
                            if (y == 3'd6) begin
                                mem_addr   = hl[ADDR_BITS-1:0];
                                state_next = S_MEMRD;
                            end else begin
                                r8_we  = 1'b1;
                                r8_val = alu_res.value;
                                f_next = alu_res.flags;
                            end
                        end
                        3'd6: begin
                            pc_next    = pc_reg + 16'd1;
                            state_next = S_IMM_LO;
                        end
                        default: begin
                            a_next = alu_res.value;
                            f_next = alu_res.flags;
                        end
                    endcase
                end
            end
            S_IMM_LO: begin
                lo_next    = mem_rdata;
                state_next = S_DONE;
                if (z == 3'd1 || (z == 3'd0 && y == 3'd1)) begin
                    pc_next    = pc_reg + 16'd1;
                    state_next = S_IMM_HI;
                end else if (z == 3'd0) begin
                    case (y)
                        3'd4: take = !f_reg[FLAG_Z];
                        3'd5: take = f_reg[FLAG_Z];
                        3'd6: take = !f_reg[FLAG_C];
                        3'd7: take = f_reg[FLAG_C];
                        default: take = 1'b1;
                    endcase
                    if (take) begin
                        pc_next = pc_reg + {{8{mem_rdata[7]}}, mem_rdata};
                    end
                end else if (y == 3'd6) begin
                    mem_we    = 1'b1;
                    mem_addr  = hl[ADDR_BITS-1:0];
                    mem_wdata = mem_rdata;
                end else begin
                    r8_we  = 1'b1;
                    r8_val = mem_rdata;
                end
            end
            S_IMM_HI: begin
                hi_next = mem_rdata;
                if (z == 3'd0) begin
                    t16        = {mem_rdata, lo_reg};
                    mem_we     = 1'b1;
                    mem_addr   = t16[ADDR_BITS-1:0];
                    mem_wdata  = sp_reg[7:0];
                    state_next = S_WR2;
                end else begin
                    pr_we      = 1'b1;
                    pr_val     = {mem_rdata, lo_reg};
                    state_next = S_DONE;
                end
            end
            S_WR2: begin
                t16        = {hi_reg, lo_reg} + 16'd1;
                mem_we     = 1'b1;
                mem_addr   = t16[ADDR_BITS-1:0];
                mem_wdata  = sp_reg[15:8];
                state_next = S_DONE;
            end
            S_MEMRD: begin
                state_next = S_DONE;
                if (op_reg >= OP_LDBLK) begin
                    r8_we  = 1'b1;
                    r8_val = mem_rdata;
                end else if (z == 3'd2) begin
                    a_next = mem_rdata;
                end else begin
                    mem_we    = 1'b1;
                    mem_addr  = hl[ADDR_BITS-1:0];
                    mem_wdata = alu_res.value;
                    f_next    = alu_res.flags;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (r8_we) begin
            case (r8_idx)
                3'd0: b_next = r8_val;
                3'd1: c_next = r8_val;
                3'd2: d_next = r8_val;
                3'd3: e_next = r8_val;
                3'd4: h_next = r8_val;
                3'd5: l_next = r8_val;
                3'd7: a_next = r8_val;
                default: a_next = a_reg;
            endcase
        end
        if (pr_we) begin
            case (pr_idx)
                2'd0: begin b_next = pr_val[15:8]; c_next = pr_val[7:0]; end
                2'd1: begin d_next = pr_val[15:8]; e_next = pr_val[7:0]; end
                2'd2: begin h_next = pr_val[15:8]; l_next = pr_val[7:0]; end
                default: sp_next = pr_val;
            endcase
        end

        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            pc_reg      <= PC_RESET;
            sp_reg      <= SP_RESET;
            a_reg       <= 8'h00;
            f_reg       <= 4'h0;
            b_reg       <= 8'h00;
            c_reg       <= 8'h00;
            d_reg       <= 8'h00;
            e_reg       <= 8'h00;
            h_reg       <= 8'h00;
            l_reg       <= 8'h00;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            pc_reg      <= pc_next;
            sp_reg      <= sp_next;
            a_reg       <= a_next;
            f_reg       <= f_next;
            b_reg       <= b_next;
            c_reg       <= c_next;
            d_reg       <= d_next;
            e_reg       <= e_next;
            h_reg       <= h_next;
            l_reg       <= l_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg <= op_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        rd_reg <= rd_next;
        st_reg <= st_next;
        if (load_out) begin
            m_pc_reg     <= pc_reg;
            m_sp_reg     <= sp_reg;
            m_acc_reg    <= a_reg;
            m_flags_reg  <= f_reg;
            m_b_reg      <= b_reg;
            m_c_reg      <= c_reg;
            m_d_reg      <= d_reg;
            m_e_reg      <= e_reg;
            m_h_reg      <= h_reg;
            m_l_reg      <= l_reg;
            m_rd_reg     <= rd_reg;
            m_status_reg <= st_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pc        = m_pc_reg;
    assign m_sp        = m_sp_reg;
    assign m_acc       = m_acc_reg;
    assign m_flags     = m_flags_reg;
    assign m_reg_b     = m_b_reg;
    assign m_reg_c     = m_c_reg;
    assign m_reg_d     = m_d_reg;
    assign m_reg_e     = m_e_reg;
    assign m_reg_h     = m_h_reg;
    assign m_reg_l     = m_l_reg;
    assign m_read_data = m_rd_reg;
    assign m_status    = m_status_reg;

`ifndef NO_ASSERTIONS
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready)
        else $error("item accepted during memory clear");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != S_IDLE && state_reg != S_CLEAR)
        else $error("accepted item did not start");
    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_valid_reg && state_reg == S_IDLE)
        else $error("finished item not presented");
    a_status_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg |-> m_rd_reg == 8'h00)
        else $error("unimplemented opcode carries read data");
`endif
endmodule
